// File: src/bppc_pkg.sv
`default_nettype none

package bppc_pkg;

  localparam int unsigned MaxPlanes = 6;
  localparam int unsigned EhbPlanes = 6;
  localparam int unsigned PalDepth  = 32;
  localparam int unsigned PalAw     = $clog2(PalDepth);

  localparam logic       KindColor = 1'b0;
  localparam logic       KindPixel = 1'b1;

  localparam logic [1:0] RegDualPf   = 2'd0;
  localparam logic [1:0] RegPlaneCnt = 2'd1;
  localparam logic [1:0] RegPf2Pri   = 2'd2;
  localparam logic [1:0] RegHires    = 2'd3;

  typedef logic [15:0] rgb565_t;
  typedef logic [5:0]  pal_idx_t;

  function automatic rgb565_t rgb444_to_565(input logic [11:0] c);
    rgb565_t res;
    res = {c[11:8], c[11], c[7:4], c[7:6], c[3:0], c[3]};
    return res;
  endfunction

  function automatic rgb565_t half_bright(input rgb565_t c);
    rgb565_t res;
    res = {1'b0, c[15:12], 1'b0, c[10:6], 1'b0, c[4:1]};
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/bitplane_palette_compositor_top.sv
`default_nettype none

// channel | handshake             | payload
// --------+-----------------------+-------------------------------------------------
// in      | in_valid / in_stall   | in_kind, in_color_slot, in_color_value, in_plane_bits
// out     | out_valid / out_stall | out_pixel_rgb565, out_palette_index, out_last
// cfg     | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// a pixel is issued as one copy in hires and two copies in lores; the output register
// issues one copy per cycle while out_stall is low, so the copy count sets the sustained rate.
// a color write goes to the palette memory at acceptance and produces no result.
// a pixel reads the palette at acceptance into the registered read stage, then enters the output register.
// reset (rst_n low, synchronous) clears the 32 palette valid bits and all control state.
// out_stall holds the output register; in_stall rises only when the read stage cannot drain.

module bitplane_palette_compositor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [4:0]  in_color_slot,
  input  wire logic [11:0] in_color_value,
  input  wire logic [5:0]  in_plane_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_pixel_rgb565,
  output logic [5:0]       out_palette_index,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic       dual_pf_r;
  logic [2:0] plane_cnt_r;
  logic       pf2_pri_r;
  logic       hires_r;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dual_pf_r   <= 1'b0;
      plane_cnt_r <= 3'd0;
      pf2_pri_r   <= 1'b0;
      hires_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bppc_pkg::RegDualPf:   dual_pf_r   <= pwdata[0];
        bppc_pkg::RegPlaneCnt: plane_cnt_r <= pwdata[2:0];
        bppc_pkg::RegPf2Pri:   pf2_pri_r   <= pwdata[0];
        bppc_pkg::RegHires:    hires_r     <= pwdata[0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[3:2])
      bppc_pkg::RegDualPf:   prdata = {31'd0, dual_pf_r};
      bppc_pkg::RegPlaneCnt: prdata = {29'd0, plane_cnt_r};
      bppc_pkg::RegPf2Pri:   prdata = {31'd0, pf2_pri_r};
      bppc_pkg::RegHires:    prdata = {31'd0, hires_r};
      default:               prdata = 32'd0;
    endcase
  end

  // read stage and output register state
  logic                  s1_vld_r;
  logic                  s1_hires_r;
  logic                  s1_ehb_r;
  logic                  s1_hit_r;
  bppc_pkg::pal_idx_t    s1_idx_r;
  bppc_pkg::rgb565_t     rd_data_r;

  logic                  out_vld_r;
  logic                  out_last_r;
  bppc_pkg::rgb565_t     out_rgb_r;
  bppc_pkg::pal_idx_t    out_idx_r;

  logic out_acc;
  logic s1_mv;
  logic in_acc;

  assign out_acc  = out_vld_r && !out_stall;
  assign s1_mv    = s1_vld_r && (!out_vld_r || (out_acc && out_last_r));
  assign in_stall = s1_vld_r && !s1_mv;
  assign in_acc   = in_valid && !in_stall;

  // index decode
  logic [2:0]         n_planes;
  logic [5:0]         plane_mask;
  logic [5:0]         bits;
  logic [2:0]         pf1;
  logic [2:0]         pf2;
  bppc_pkg::pal_idx_t idx;
  logic               ehb;

  always_comb begin
    n_planes = (plane_cnt_r > 3'(bppc_pkg::MaxPlanes)) ? 3'(bppc_pkg::MaxPlanes)
                                                         : plane_cnt_r;
    plane_mask = ~(6'h3f << n_planes);
    bits = in_plane_bits & plane_mask;
    pf1  = {bits[4], bits[2], bits[0]};
    pf2  = {bits[5], bits[3], bits[1]};
    ehb  = 1'b0;
    if (dual_pf_r) begin
      if (pf1 != 3'd0 && (pf2 == 3'd0 || !pf2_pri_r)) begin
        idx = {3'd0, pf1};
      end else if (pf2 != 3'd0) begin
        idx = {3'd1, pf2};
      end else begin
        idx = 6'd0;
      end
    end else begin
      idx = bits;
      ehb = (n_planes == 3'(bppc_pkg::EhbPlanes)) && bits[5];
    end
  end

  // palette memory with reset-cleared valid bits
  bppc_pkg::rgb565_t              pal_mem_r [bppc_pkg::PalDepth];
  logic [bppc_pkg::PalDepth-1:0]  pal_vld_r;
  logic [bppc_pkg::PalAw-1:0]     rd_addr;

  logic pal_wr;
  logic pal_rd;
  assign pal_wr  = in_acc && (in_kind == bppc_pkg::KindColor);
  assign pal_rd  = in_acc && (in_kind == bppc_pkg::KindPixel);
  assign rd_addr = idx[bppc_pkg::PalAw-1:0];

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem_r[in_color_slot] <= bppc_pkg::rgb444_to_565(in_color_value);
    end
    if (pal_rd) begin
      rd_data_r <= pal_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (pal_wr) begin
      pal_vld_r[in_color_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (pal_rd) begin
      s1_vld_r <= 1'b1;
    end else if (s1_mv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_rd) begin
      s1_hires_r <= hires_r;
      s1_ehb_r   <= ehb;
      s1_hit_r   <= pal_vld_r[rd_addr];
      s1_idx_r   <= idx;
    end
  end

  // output register, repeats the pixel for lores
  bppc_pkg::rgb565_t s1_color;
  always_comb begin
    s1_color = s1_hit_r ? rd_data_r : 16'd0;
    if (s1_ehb_r) begin
      s1_color = bppc_pkg::half_bright(s1_color);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else if (s1_mv) begin
      out_vld_r  <= 1'b1;
      out_last_r <= s1_hires_r;
    end else if (out_acc) begin
      if (out_last_r) begin
        out_vld_r <= 1'b0;
      end else begin
        out_last_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      out_rgb_r <= s1_color;
      out_idx_r <= s1_idx_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_pixel_rgb565  = out_rgb_r;
  assign out_palette_index = out_idx_r;
  assign out_last          = out_last_r;

  a_second_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_last_r |=> out_vld_r && out_last_r && $stable(out_rgb_r)
                               && $stable(out_idx_r))
    else $error("lores second copy lost or changed");

  a_hires_single: assert property (@(posedge clk) disable iff (!rst_n)
    s1_mv && s1_hires_r |=> out_vld_r && out_last_r)
    else $error("hires pixel not marked last");

  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pal_wr |=> pal_vld_r[$past(in_color_slot)])
    else $error("palette write did not set valid bit");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_mv |=> s1_vld_r && $stable(s1_idx_r) && $stable(rd_data_r))
    else $error("read stage overwritten while stalled");

endmodule

`default_nettype wire
